// ===== hdl/mmpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpe_pkg
// Shared types, constants and the power table for the matrix power engine.
// ----------------------------------------------------------------------------
package mmpe_pkg;

   localparam int DIM        = 4;
   localparam int COL_W      = 2;
   localparam int EXPONENT_W = 31;
   localparam int ENTRY_W    = 30;
   localparam int ROM_DEPTH  = 31;
   localparam int ROM_IDX_W  = 5;
   localparam int PROD_W     = 2 * ENTRY_W;
   localparam int RED_W      = 32;

   localparam logic [ENTRY_W-1:0] PRIME = 30'd998244353;

   // Barrett factor floor(2^60 / P), 31 bits wide
   localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'(PRIME);
   localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

   typedef logic [ENTRY_W-1:0] elem_type;
   typedef elem_type [DIM-1:0][DIM-1:0] mat_type;
   typedef mat_type [ROM_DEPTH-1:0] rom_type;
   typedef elem_type [DIM-1:0] vec_type;

   localparam logic [1:0] BASE_ENTRY [DIM][DIM] = '{
      '{2'd1, 2'd1, 2'd0, 2'd0},
      '{2'd1, 2'd2, 2'd0, 2'd1},
      '{2'd1, 2'd2, 2'd1, 2'd2},
      '{2'd0, 2'd0, 2'd1, 2'd1}
   };

   // Repeated squaring of the base matrix, reduced modulo the prime
   function automatic rom_type build_power_rom();
      rom_type     rom;
      logic [63:0] acc;
      rom = '0;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            rom[0][r][c] = elem_type'(BASE_ENTRY[r][c]);
         end
      end
      for (int i = 1; i < ROM_DEPTH; i++) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               acc = 64'd0;
               for (int k = 0; k < DIM; k++) begin
                  acc = (acc + 64'(rom[i-1][r][k]) * 64'(rom[i-1][k][c])) % 64'(PRIME);
               end
               rom[i][r][c] = elem_type'(acc);
            end
         end
      end
      return rom;
   endfunction

   localparam rom_type POWER_ROM = build_power_rom();

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_ISSUE  = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic step_bit;
      logic issue;
      logic commit;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic bit_set;
      logic last_bit;
      logic last_col;
      logic pipe_busy;
   } status_type;

endpackage

// ===== hdl/mmpe_req_if.sv =====
// ----------------------------------------------------------------------------
// mmpe_req_if
// Request channel: one exponent per transaction.
// ----------------------------------------------------------------------------
interface mmpe_req_if;
   logic                             valid;
   logic                             ready;
   logic [mmpe_pkg::EXPONENT_W-1:0] exponent;

   modport source (output valid, output exponent, input ready);
   modport sink   (input valid, input exponent, output ready);
endinterface

// ===== hdl/mmpe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mmpe_rsp_if
// Response channel: one matrix entry per transaction.
// ----------------------------------------------------------------------------
interface mmpe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mmpe_pkg::ENTRY_W-1:0] entry_value;

   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface

// ===== hdl/mmpe_mulred.sv =====
// ----------------------------------------------------------------------------
// mmpe_mulred
// Four-stage modular multiplier: product, then Barrett reduction.
// ----------------------------------------------------------------------------
module mmpe_mulred (
   input  logic                        clock,
   input  logic [mmpe_pkg::ENTRY_W-1:0] a,
   input  logic [mmpe_pkg::ENTRY_W-1:0] b,
   output logic [mmpe_pkg::ENTRY_W-1:0] result
);

   logic [mmpe_pkg::PROD_W-1:0] prod_ff;
   logic [mmpe_pkg::PROD_W-1:0] prod_in;
   logic [61:0]                  q2_ff;
   logic [61:0]                  q2_in;
   logic [mmpe_pkg::RED_W-1:0]  x2_ff;
   logic [mmpe_pkg::RED_W-1:0]  x3_ff;
   logic [mmpe_pkg::RED_W-1:0]  qp_ff;
   logic [mmpe_pkg::RED_W-1:0]  qp_in;
   logic [30:0]                  q3;
   logic [mmpe_pkg::RED_W-1:0]  rem;
   logic [mmpe_pkg::RED_W-1:0]  prime_w;
   logic [mmpe_pkg::ENTRY_W-1:0] res_ff;
   logic [mmpe_pkg::ENTRY_W-1:0] res_in;

   assign prime_w = mmpe_pkg::RED_W'(mmpe_pkg::PRIME);
   assign prod_in = mmpe_pkg::PROD_W'(a) * mmpe_pkg::PROD_W'(b);
   assign q2_in   = 62'(prod_ff[59:29]) * 62'(mmpe_pkg::BARRETT_MU);
   assign q3      = q2_ff[61:31];
   // low word suffices: the remainder stays below three times the prime
   assign qp_in   = mmpe_pkg::RED_W'(q3) * prime_w;
   assign rem     = x3_ff - qp_ff;

   always_comb begin
      if (rem >= (prime_w << 1)) begin
         res_in = mmpe_pkg::ENTRY_W'(rem - (prime_w << 1));
      end else if (rem >= prime_w) begin
         res_in = mmpe_pkg::ENTRY_W'(rem - prime_w);
      end else begin
         res_in = mmpe_pkg::ENTRY_W'(rem);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q2_ff   <= q2_in;
      x2_ff   <= prod_ff[mmpe_pkg::RED_W-1:0];
      qp_ff   <= qp_in;
      x3_ff   <= x2_ff;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

// ===== hdl/mmpe_datapath.sv =====
// ----------------------------------------------------------------------------
// mmpe_datapath
// Row vector, exponent scan, power table and four modular multiply lanes.
// ----------------------------------------------------------------------------
module mmpe_datapath #(
   parameter int EXPONENT_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mmpe_pkg::cmd_type              cmd,
   input  logic [mmpe_pkg::EXPONENT_W-1:0] exponent,
   output mmpe_pkg::status_type           status,
   output logic [mmpe_pkg::ENTRY_W-1:0]   entry_value
);

   localparam int BIT_IDX_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;
   localparam int LANE_LAT  = 4;

   logic [EXPONENT_BITS-1:0]     exp_ff;
   logic [EXPONENT_BITS-1:0]     exp_in;
   logic [BIT_IDX_W-1:0]         bit_idx_ff;
   logic [BIT_IDX_W-1:0]         bit_idx_in;
   logic [mmpe_pkg::COL_W-1:0]   col_ff;
   logic [mmpe_pkg::COL_W-1:0]   col_in;
   mmpe_pkg::vec_type            vec_ff;
   mmpe_pkg::vec_type            vec_in;
   mmpe_pkg::vec_type            nvec_ff;
   mmpe_pkg::vec_type            nvec_in;
   logic [LANE_LAT-1:0]          tag_valid_ff;
   logic [LANE_LAT-1:0]          tag_valid_in;
   logic [LANE_LAT-1:0][mmpe_pkg::COL_W-1:0] tag_col_ff;
   logic [LANE_LAT-1:0][mmpe_pkg::COL_W-1:0] tag_col_in;
   logic [mmpe_pkg::ENTRY_W-1:0] out_ff;
   logic [mmpe_pkg::ENTRY_W-1:0] out_in;
   logic [mmpe_pkg::ROM_IDX_W-1:0] rom_idx;
   mmpe_pkg::mat_type            power_mat;
   mmpe_pkg::vec_type            lane_res;
   logic [mmpe_pkg::RED_W-1:0]   col_sum;
   logic [mmpe_pkg::RED_W-1:0]   prime_w;
   logic [mmpe_pkg::ENTRY_W-1:0] col_red;

   assign rom_idx   = mmpe_pkg::ROM_IDX_W'(bit_idx_ff);
   assign power_mat = mmpe_pkg::POWER_ROM[rom_idx];
   assign prime_w   = mmpe_pkg::RED_W'(mmpe_pkg::PRIME);

   for (genvar k = 0; k < mmpe_pkg::DIM; k++) begin : g_lane
      mmpe_mulred u_mulred (
         .clock  (clock),
         .a      (vec_ff[k]),
         .b      (power_mat[k][col_ff]),
         .result (lane_res[k])
      );
   end

   assign col_sum = mmpe_pkg::RED_W'(lane_res[0]) + mmpe_pkg::RED_W'(lane_res[1])
                  + mmpe_pkg::RED_W'(lane_res[2]) + mmpe_pkg::RED_W'(lane_res[3]);

   always_comb begin
      if (col_sum >= 3 * prime_w) begin
         col_red = mmpe_pkg::ENTRY_W'(col_sum - 3 * prime_w);
      end else if (col_sum >= (prime_w << 1)) begin
         col_red = mmpe_pkg::ENTRY_W'(col_sum - (prime_w << 1));
      end else if (col_sum >= prime_w) begin
         col_red = mmpe_pkg::ENTRY_W'(col_sum - prime_w);
      end else begin
         col_red = mmpe_pkg::ENTRY_W'(col_sum);
      end
   end

   always_comb begin
      exp_in       = exp_ff;
      bit_idx_in   = bit_idx_ff;
      col_in       = col_ff;
      vec_in       = vec_ff;
      nvec_in      = nvec_ff;
      out_in       = out_ff;
      tag_valid_in = {tag_valid_ff[LANE_LAT-2:0], cmd.issue};
      tag_col_in   = {tag_col_ff[LANE_LAT-2:0], col_ff};
      if (cmd.load) begin
         exp_in     = exponent[EXPONENT_BITS-1:0];
         bit_idx_in = BIT_IDX_W'(EXPONENT_BITS - 1);
         col_in     = '0;
         vec_in     = '0;
         vec_in[0]  = mmpe_pkg::ENTRY_W'(1);
      end
      if (cmd.step_bit) begin
         exp_in     = exp_ff << 1;
         bit_idx_in = bit_idx_ff - BIT_IDX_W'(1);
      end
      if (cmd.issue) begin
         col_in = col_ff + mmpe_pkg::COL_W'(1);
      end
      if (tag_valid_ff[LANE_LAT-1]) begin
         nvec_in[tag_col_ff[LANE_LAT-1]] = col_red;
      end
      if (cmd.commit) begin
         vec_in = nvec_ff;
      end
      if (cmd.load_out) begin
         out_in = vec_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= '0;
      end else begin
         tag_valid_ff <= tag_valid_in;
      end
      exp_ff     <= exp_in;
      bit_idx_ff <= bit_idx_in;
      col_ff     <= col_in;
      vec_ff     <= vec_in;
      nvec_ff    <= nvec_in;
      tag_col_ff <= tag_col_in;
      out_ff     <= out_in;
   end

   assign status.bit_set   = exp_ff[EXPONENT_BITS-1];
   assign status.last_bit  = (bit_idx_ff == '0);
   assign status.last_col  = (col_ff == mmpe_pkg::COL_W'(mmpe_pkg::DIM - 1));
   assign status.pipe_busy = |tag_valid_ff;
   assign entry_value      = out_ff;

endmodule

// ===== hdl/mmpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmpe_ctrl
// Sequencer: scan exponent bits, issue columns, drain, commit, deliver.
// ----------------------------------------------------------------------------
module mmpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mmpe_pkg::status_type status,
   output mmpe_pkg::cmd_type    cmd
);

   mmpe_pkg::state_type state_ff;
   mmpe_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mmpe_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mmpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mmpe_pkg::ST_SCAN;
            end
         end
         mmpe_pkg::ST_SCAN: begin
            if (status.bit_set) begin
               state_in = mmpe_pkg::ST_ISSUE;
            end else if (status.last_bit) begin
               state_in = mmpe_pkg::ST_FINISH;
            end else begin
               cmd.step_bit = 1'b1;
            end
         end
         mmpe_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.last_col) begin
               state_in = mmpe_pkg::ST_DRAIN;
            end
         end
         mmpe_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.commit = 1'b1;
               if (status.last_bit) begin
                  state_in = mmpe_pkg::ST_FINISH;
               end else begin
                  cmd.step_bit = 1'b1;
                  state_in     = mmpe_pkg::ST_SCAN;
               end
            end
         end
         mmpe_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = mmpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmpe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/modular_matrix_power_entry_core.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_entry_core
// Entry (0,0) of a fixed 4x4 matrix raised to a given power, modulo 998244353.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A request is taken while the
// engine is idle, even when the previous result is still waiting in the output
// register. The engine scans EXPONENT_BITS exponent bits from the top: a clear
// bit is only stepped over in the scan state, while a set bit takes a scan step,
// four column issues into the four multiply lanes, a drain of the lane
// pipeline and one commit. The lane pipeline depth and its drain before each
// commit set the cost of a set bit.
module modular_matrix_power_entry_core #(
   parameter int EXPONENT_BITS = 31
) (
   input  logic         clock,
   input  logic         reset,
   mmpe_req_if.sink     req_channel,
   mmpe_rsp_if.source   rsp_channel
);

   mmpe_pkg::cmd_type    cmd;
   mmpe_pkg::status_type status;

   mmpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmpe_datapath #(
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .exponent    (req_channel.exponent),
      .status      (status),
      .entry_value (rsp_channel.entry_value)
   );

   // commit only once every column has left the lanes
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.pipe_busy)
      else $error("vector committed while lanes busy");

   // never overwrite a result that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_channel.valid || rsp_channel.ready))
      else $error("pending result overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.ready && !cmd.load_out) |=> !rsp_channel.valid)
      else $error("result repeated after transaction");

   assert property (@(posedge clock) disable iff (reset)
      (req_channel.valid && req_channel.ready) |-> !status.pipe_busy)
      else $error("request taken with lanes busy");

endmodule

// ===== tb/sv/tb_modular_matrix_power_entry_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_matrix_power_entry_core
// Self-checking bench for the matrix power entry core.
// ----------------------------------------------------------------------------
// Exponents are sent through the request channel under three pacing phases.
// Each accepted exponent is turned into the expected (0,0) entry of B^N mod P
// by an independent model that builds its own table of squared powers.
// Responses are checked in order. One long output stall forces the core to
// back up and hold off new requests.
// ----------------------------------------------------------------------------
module tb_modular_matrix_power_entry_core;

   localparam int          CLOCK_PERIOD  = 8;
   localparam int          RESET_CYCLES  = 6;
   localparam int          RANDOM_ITEMS  = 1830;
   localparam int          HOLD_CYCLES   = 1500;
   localparam int          DRAIN_CYCLES  = 400;
   localparam int          CYCLE_LIMIT   = 4000000;
   localparam logic [63:0] MODULUS       = 64'd998244353;

   typedef logic [mmpe_pkg::EXPONENT_W-1:0] exponent_type;

   logic clock = 1'b0;
   logic reset;

   mmpe_req_if req_bus ();
   mmpe_rsp_if rsp_bus ();

   modular_matrix_power_entry_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   logic [63:0]        squared_powers [mmpe_pkg::EXPONENT_W][mmpe_pkg::DIM][mmpe_pkg::DIM];
   exponent_type       pending_exponents [$];
   mmpe_pkg::elem_type expected_entries [$];
   int                 total_items;
   int                 accepted_count;
   int                 checked_count;
   int                 error_count;
   int                 cycle_count;
   int                 hold_cycles_left;
   bit                 hold_done;
   mmpe_pkg::elem_type wanted_entry;

   // B^(2^i) mod P by repeated squaring
   function automatic void build_squared_powers();
      logic [63:0] acc;
      logic [1:0]  base [mmpe_pkg::DIM][mmpe_pkg::DIM];
      base = '{'{2'd1, 2'd1, 2'd0, 2'd0},
               '{2'd1, 2'd2, 2'd0, 2'd1},
               '{2'd1, 2'd2, 2'd1, 2'd2},
               '{2'd0, 2'd0, 2'd1, 2'd1}};
      for (int r = 0; r < mmpe_pkg::DIM; r++) begin
         for (int c = 0; c < mmpe_pkg::DIM; c++) begin
            squared_powers[0][r][c] = 64'(base[r][c]);
         end
      end
      for (int i = 1; i < mmpe_pkg::EXPONENT_W; i++) begin
         for (int r = 0; r < mmpe_pkg::DIM; r++) begin
            for (int c = 0; c < mmpe_pkg::DIM; c++) begin
               acc = 64'd0;
               for (int k = 0; k < mmpe_pkg::DIM; k++) begin
                  acc = (acc + squared_powers[i-1][r][k] * squared_powers[i-1][k][c])
                        % MODULUS;
               end
               squared_powers[i][r][c] = acc;
            end
         end
      end
   endfunction

   // Row vector (1,0,0,0) times B^(2^i) for every set bit, top bit first
   function automatic mmpe_pkg::elem_type matrix_power_entry(exponent_type exponent);
      logic [63:0] row [mmpe_pkg::DIM];
      logic [63:0] next_row [mmpe_pkg::DIM];
      logic [63:0] acc;
      row = '{64'd1, 64'd0, 64'd0, 64'd0};
      for (int i = mmpe_pkg::EXPONENT_W - 1; i >= 0; i--) begin
         if (exponent[i]) begin
            for (int c = 0; c < mmpe_pkg::DIM; c++) begin
               acc = 64'd0;
               for (int k = 0; k < mmpe_pkg::DIM; k++) begin
                  acc = (acc + row[k] * squared_powers[i][k][c]) % MODULUS;
               end
               next_row[c] = acc;
            end
            row = next_row;
         end
      end
      return mmpe_pkg::elem_type'(row[0]);
   endfunction

   function automatic exponent_type random_exponent();
      exponent_type value;
      case ($urandom_range(0, 5))
         0: value = exponent_type'($urandom);
         1: value = exponent_type'($urandom_range(0, 255));
         2: value = (exponent_type'(1) << $urandom_range(0, mmpe_pkg::EXPONENT_W - 1))
                  | (exponent_type'(1) << $urandom_range(0, mmpe_pkg::EXPONENT_W - 1));
         3: value = ~(exponent_type'(1) << $urandom_range(0, mmpe_pkg::EXPONENT_W - 1));
         4: value = exponent_type'($urandom & $urandom);
         default: value = exponent_type'($urandom | $urandom);
      endcase
      return value;
   endfunction

   // Pacing phase follows progress through the stimulus
   function automatic int pacing_phase();
      if (accepted_count < total_items / 3) begin
         return 0;
      end else if (accepted_count < (2 * total_items) / 3) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic bit sender_idles();
      int roll;
      roll = $urandom_range(0, 99);
      case (pacing_phase())
         0: return roll < 32;
         1: return roll < 77;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_idles();
      int roll;
      roll = $urandom_range(0, 99);
      case (pacing_phase())
         0: return roll < 77;
         1: return roll < 32;
         default: return 1'b0;
      endcase
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_entries = {expected_entries, matrix_power_entry(req_bus.exponent)};
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_exponents.size() > 0 && !sender_idles()) begin
               req_bus.valid    <= 1'b1;
               req_bus.exponent <= pending_exponents.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long output stall once the core is running flat out
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles_left <= 0;
         hold_done        <= 1'b0;
      end else if (hold_cycles_left > 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
      end else if (!hold_done && accepted_count >= (5 * total_items) / 6) begin
         hold_cycles_left <= HOLD_CYCLES;
         hold_done        <= 1'b1;
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_entries.size() == 0) begin
               $error("unexpected transaction: entry_value %0d", rsp_bus.entry_value);
               error_count++;
            end else begin
               wanted_entry = expected_entries.pop_front();
               checked_count++;
               if (rsp_bus.entry_value !== wanted_entry) begin
                  $error("entry_value mismatch: expected %0d, actual %0d",
                         wanted_entry, rsp_bus.entry_value);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= (hold_cycles_left == 0) && !receiver_idles();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      exponent_type directed [$];
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.exponent = '0;
      rsp_bus.ready    = 1'b0;
      accepted_count   = 0;
      checked_count    = 0;
      error_count      = 0;
      cycle_count      = 0;
      build_squared_powers();

      directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7,
                   31'h4000_0000, 31'h7FFF_FFFF, 31'h3FFF_FFFF, 31'h5555_5555,
                   31'h2AAA_AAAA, 31'h4000_0001, 31'h0000_8000, 31'd998244353,
                   31'd998244352, 31'd12345, 31'h7FFF_FFFE, 31'h0F0F_0F0F,
                   31'h70F0_F0F0};
      pending_exponents = directed;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_exponents = {pending_exponents, random_exponent()};
      end
      total_items = pending_exponents.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_exponents.size() > 0 || req_bus.valid) @(posedge clock);
      while (expected_entries.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d exponents sent, %0d responses checked", total_items, checked_count);
      $display("tb: covered both skewed pacing phases, full rate and one long output stall");
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
